/* hw/rtl/dbc_pkg.sv */
// Shared types, constants and the byte-wide CRC update for the disk block checksum.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dbc_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] CRC_INIT_RESET = 16'h8000;
  localparam logic [7:0]  ZERO_BYTE      = 8'h00;

  // Finished block sum (before the two trailing zero bytes) moving downstream.
  typedef struct packed {
    logic        valid;
    logic [15:0] sum;
  } dbc_tail_t;

  // Shift one byte into the register, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    logic        carry;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      carry = crc[0];
      crc   = {data[k], crc[15:1]};
      if (carry) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/dbc_accum.sv */
// Input register and running checksum register of the disk block checksum.
// Depends on dbc_pkg for the byte update and the tail handoff struct.
`timescale 1ns / 1ps

module dbc_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  output dbc_pkg::dbc_tail_t tail,
  input  logic              tail_ready
);
  import dbc_pkg::*;

  logic        s1_v_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [15:0] sum_r;
  logic [15:0] init_r;
  logic [15:0] sum_nxt;
  logic        move;
  logic        accept;

  // The held byte leaves unless it closes a block and the tail slot is full.
  assign move     = s1_v_r && (!s1_last_r || tail_ready);
  assign in_stall = s1_v_r && s1_last_r && !tail_ready;
  assign accept   = in_valid && !in_stall;
  assign sum_nxt  = crc_byte(sum_r, s1_byte_r);

  assign tail.valid = s1_v_r && s1_last_r;
  assign tail.sum   = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      sum_r  <= CRC_INIT_RESET;
      init_r <= CRC_INIT_RESET;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        init_r <= cfg_wr_data;
        sum_r  <= cfg_wr_data;
      end else if (move) begin
        sum_r <= s1_last_r ? init_r : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !move && !accept |=> s1_v_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("held input byte changed");
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    move && s1_last_r && !cfg_wr_en |=> sum_r == $past(init_r))
    else $error("checksum not reloaded after block end");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> sum_r == $past(cfg_wr_data) && init_r == $past(cfg_wr_data))
    else $error("initial value write not applied");
`endif

endmodule

/* hw/rtl/dbc_finish.sv */
// Tail pipeline: shifts the two implied zero bytes into a finished block sum and
// holds the checksum in the output register. Depends on dbc_pkg.
`timescale 1ns / 1ps

module dbc_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  dbc_pkg::dbc_tail_t tail,
  output logic               tail_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_checksum
);
  import dbc_pkg::*;

  logic        a_v_r;
  logic [15:0] a_sum_r;
  logic        b_v_r;
  logic [15:0] b_sum_r;
  logic        out_v_r;
  logic [15:0] out_sum_r;
  logic        adv_out;
  logic        ready_b;

  assign adv_out    = !out_v_r || !out_stall;
  assign ready_b    = !b_v_r || adv_out;
  assign tail_ready = !a_v_r || ready_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (tail_ready) begin
        a_v_r <= tail.valid;
      end
      if (ready_b) begin
        b_v_r <= a_v_r;
      end
      if (adv_out) begin
        out_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_ready) begin
      a_sum_r <= tail.sum;
    end
    if (ready_b) begin
      b_sum_r <= crc_byte(a_sum_r, ZERO_BYTE);
    end
    if (adv_out) begin
      out_sum_r <= crc_byte(b_sum_r, ZERO_BYTE);
    end
  end

  assign out_valid    = out_v_r;
  assign out_checksum = out_sum_r;

`ifndef NO_ASSERTIONS
  a_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !ready_b |=> a_v_r && $stable(a_sum_r))
    else $error("first tail stage lost its sum");
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !adv_out |=> b_v_r && $stable(b_sum_r))
    else $error("second tail stage lost its sum");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_sum_r))
    else $error("stalled checksum changed");
`endif

endmodule

/* hw/rtl/disk_block_crc16_core.sv */
// Path: a byte marked last goes from the input register through tail stages a and b to the output register.
// Throughput: one byte per cycle while in_stall is low; a stalled result is absorbed by the pipeline slots behind it.
// Reset: synchronous, active low; initial value and running checksum return to 0x8000.
// One eight-bit unrolled CRC update runs for the byte, then one for each zero byte in stage b and the output register.
// Depends on dbc_pkg, dbc_accum and dbc_finish.
`timescale 1ns / 1ps

module disk_block_crc16_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum
);
  import dbc_pkg::*;

  // Handoff of a finished block sum from the accumulator to the tail pipeline.
  // The accumulator folds the last byte in on the way out, so the tail only
  // has to add the two implied zero bytes, one each in stage b and the output register.
  dbc_tail_t tail;
  logic      tail_ready;

  // The accumulator registers each request, updates the running checksum as
  // the byte leaves the input register, and reloads the initial value at the
  // end of a block. A configuration write reloads the checksum as well.
  dbc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .tail         (tail),
    .tail_ready   (tail_ready)
  );

  // The tail pipeline has three slots, so bytes keep flowing while a finished
  // checksum waits in the output register for the sink to take it.
  dbc_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .tail         (tail),
    .tail_ready   (tail_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

endmodule
